[rtl/thermostat_with_alarm_and_history_assert.svh]
// assertion macros used by the thermostat checker
`ifndef THERMOSTAT_WITH_ALARM_AND_HISTORY_ASSERT_SVH
`define THERMOSTAT_WITH_ALARM_AND_HISTORY_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define THERMO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define THERMO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

[rtl/thermo_pkg.sv]
// ----------------------------------------------------------------------------
// thermo_pkg
// shared types and constants of the thermostat with alarm and history ring
// ----------------------------------------------------------------------------
package thermo_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 10;

  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CODE_W  = 10;
  localparam int unsigned TEMP_W  = 7;
  localparam int unsigned SCALE_W = 11;
  localparam int unsigned ENTRY_W = 8;
  localparam int unsigned NUM_W   = 4;
  localparam int unsigned EV_W    = 2;

  localparam logic [TEMP_W-1:0] SETPOINT_RST  = 7'd25;
  localparam logic [TEMP_W-1:0] THRESHOLD_RST = 7'd25;

  // register index, taken from paddr[2]
  localparam logic REG_SETPOINT  = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_DUMP   = 1'b1;

  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_RAISED  = 2'd1;
  localparam logic [EV_W-1:0] EV_CLEARED = 2'd2;

  // code * 1100 / 1024, then / 10 as * 3277 >> 15 (exact for inputs below 1099)
  localparam logic [20:0] SCALE_MUL = 21'd1100;
  localparam logic [11:0] DIV10_MUL = 12'd3277;
  localparam logic [ENTRY_W-1:0] ERASED_VAL = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TEMP,
    ST_UPD,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic scale;
    logic smp_out;
    logic dump_rd;
    logic dump_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_cmd;
    logic out_free;
    logic dump_last;
  } ctrl_sts_t;

endpackage

[rtl/thermostat_with_alarm_and_history.sv]
// ----------------------------------------------------------------------------
// thermostat_with_alarm_and_history
// on/off thermostat with over-temperature alarm and a change-only history ring
// ----------------------------------------------------------------------------
//   port group   direction  handshake            content
//   in           sink       in_valid/in_ready    cmd, adc_code
//   out          source     out_valid/out_ready  temperature .. last
//   apb config   slave      psel/penable         setpoint, alarm_threshold
//
// a sample word runs through capture, scale multiply, divide-by-ten multiply,
// flag and ring update into the result register
// a dump handles each entry in turn: a registered ring read
// followed by a load of the result register
// one word is worked on at a time; the result register frees the input side
// a stalled result holds the sequencer in its output state
// reset clears the ring to the erased value at once through per-entry valid bits
// ----------------------------------------------------------------------------
module thermostat_with_alarm_and_history #(
  parameter int unsigned HISTORY_DEPTH = thermo_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [thermo_pkg::CODE_W-1:0]  adc_code_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [thermo_pkg::TEMP_W-1:0]  temperature_c_o,
  output logic                           lamp_on_o,
  output logic                           alarm_on_o,
  output logic [thermo_pkg::EV_W-1:0]    alarm_event_o,
  output logic [thermo_pkg::NUM_W-1:0]   entry_number_o,
  output logic [thermo_pkg::ENTRY_W-1:0] entry_value_o,
  output logic                           last_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [thermo_pkg::ADDR_W-1:0]  paddr,
  input  logic [thermo_pkg::DATA_W-1:0]  pwdata,
  output logic [thermo_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);
  import thermo_pkg::*;

  ctrl_cmd_t ctl_cmd;
  ctrl_sts_t ctl_sts;

  assign pready = 1'b1;

  thermo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd),
    .in_ready_o (in_ready_o)
  );

  thermo_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctl_cmd),
    .sts_o           (ctl_sts),
    .in_valid_i      (in_valid_i),
    .cmd_in_i        (cmd_i),
    .adc_code_i      (adc_code_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .temperature_c_o (temperature_c_o),
    .lamp_on_o       (lamp_on_o),
    .alarm_on_o      (alarm_on_o),
    .alarm_event_o   (alarm_event_o),
    .entry_number_o  (entry_number_o),
    .entry_value_o   (entry_value_o),
    .last_o          (last_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

endmodule

[rtl/thermo_ctrl.sv]
// ----------------------------------------------------------------------------
// thermo_ctrl
// sequencer for sample conversion and history dump
// ----------------------------------------------------------------------------
module thermo_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  thermo_pkg::ctrl_sts_t sts_i,
  output thermo_pkg::ctrl_cmd_t cmd_o,
  output logic                  in_ready_o
);
  import thermo_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = (sts_i.in_cmd == CMD_DUMP) ? ST_DUMP_RD : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
        state_d    = ST_TEMP;
      end
      ST_TEMP: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.smp_out = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd_o.dump_rd = 1'b1;
        state_d       = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.dump_out = 1'b1;
          state_d        = sts_i.dump_last ? ST_IDLE : ST_DUMP_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/thermo_dp.sv]
// ----------------------------------------------------------------------------
// thermo_dp
// conversion, control flags, history ring, config registers and result word
// ----------------------------------------------------------------------------
module thermo_dp #(
  parameter int unsigned HISTORY_DEPTH = thermo_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  thermo_pkg::ctrl_cmd_t              cmd_i,
  output thermo_pkg::ctrl_sts_t              sts_o,
  input  logic                               in_valid_i,
  input  logic                               cmd_in_i,
  input  logic [thermo_pkg::CODE_W-1:0]      adc_code_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [thermo_pkg::TEMP_W-1:0]      temperature_c_o,
  output logic                               lamp_on_o,
  output logic                               alarm_on_o,
  output logic [thermo_pkg::EV_W-1:0]        alarm_event_o,
  output logic [thermo_pkg::NUM_W-1:0]       entry_number_o,
  output logic [thermo_pkg::ENTRY_W-1:0]     entry_value_o,
  output logic                               last_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [thermo_pkg::ADDR_W-1:0]      paddr,
  input  logic [thermo_pkg::DATA_W-1:0]      pwdata,
  output logic [thermo_pkg::DATA_W-1:0]      prdata
);
  import thermo_pkg::*;

  localparam int unsigned IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(HISTORY_DEPTH - 1);

  // configuration registers
  logic [TEMP_W-1:0] setpoint_q, threshold_q;
  logic              cfg_wr;

  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q  <= SETPOINT_RST;
      threshold_q <= THRESHOLD_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SETPOINT) begin
        setpoint_q <= pwdata[TEMP_W-1:0];
      end else begin
        threshold_q <= pwdata[TEMP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? DATA_W'(threshold_q) : DATA_W'(setpoint_q);

  // conversion pipeline, one multiply per cycle
  logic [CODE_W-1:0]  adc_q;
  logic [SCALE_W-1:0] scaled_q;
  logic [TEMP_W-1:0]  temp_q;
  logic [20:0]        prod1;
  logic [22:0]        prod2;

  assign prod1 = 21'(adc_q) * SCALE_MUL;
  assign prod2 = 23'(scaled_q) * 23'(DIV10_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      adc_q <= adc_code_i;
    end
    if (cmd_i.conv) begin
      scaled_q <= prod1[20:10];
    end
    if (cmd_i.scale) begin
      temp_q <= prod2[21:15];
    end
  end

  // history ring: storage without reset, erased state tracked by valid bits
  logic [ENTRY_W-1:0]       mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_q;
  logic [IW-1:0]            wr_idx_q, ptr_q;
  logic [CW-1:0]            cnt_q, num_w;
  logic [TEMP_W-1:0]        last_rec_q;
  logic                     rec_valid_q;
  logic                     do_rec;
  logic [ENTRY_W-1:0]       rd_data_q;
  logic                     rd_vld_q;
  logic                     lamp_q, alarm_q, lamp_d, alarm_d;
  logic [EV_W-1:0]          ev_d;

  assign do_rec = cmd_i.smp_out & (!rec_valid_q || temp_q != last_rec_q);
  assign num_w  = cnt_q + CW'(1);

  always_ff @(posedge clk_i) begin
    if (do_rec) begin
      mem[wr_idx_q] <= ENTRY_W'(temp_q);
    end
    if (cmd_i.dump_rd) begin
      rd_data_q <= mem[ptr_q];
      rd_vld_q  <= vld_q[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      wr_idx_q    <= '0;
      last_rec_q  <= '0;
      rec_valid_q <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (do_rec) begin
        vld_q[wr_idx_q] <= 1'b1;
        wr_idx_q        <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + IW'(1);
        last_rec_q      <= temp_q;
        rec_valid_q     <= 1'b1;
      end
      // dump starts at the oldest entry
      if (cmd_i.load) begin
        ptr_q <= wr_idx_q;
        cnt_q <= '0;
      end else if (cmd_i.dump_out) begin
        ptr_q <= (ptr_q == IDX_LAST) ? '0 : ptr_q + IW'(1);
        cnt_q <= num_w;
      end
    end
  end

  // lamp hysteresis and alarm flag
  always_comb begin
    lamp_d  = lamp_q;
    alarm_d = alarm_q;
    ev_d    = EV_NONE;
    if (temp_q < setpoint_q) begin
      lamp_d = 1'b1;
    end else if (temp_q > setpoint_q) begin
      lamp_d = 1'b0;
    end
    if (!alarm_q && temp_q > threshold_q) begin
      alarm_d = 1'b1;
      ev_d    = EV_RAISED;
    end else if (alarm_q && temp_q <= threshold_q) begin
      alarm_d = 1'b0;
      ev_d    = EV_CLEARED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lamp_q  <= 1'b0;
      alarm_q <= 1'b0;
    end else if (cmd_i.smp_out) begin
      lamp_q  <= lamp_d;
      alarm_q <= alarm_d;
    end
  end

  // result word register
  logic out_valid_q, out_valid_d;

  assign out_valid_d = (cmd_i.smp_out | cmd_i.dump_out) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_out) begin
      temperature_c_o <= temp_q;
      lamp_on_o       <= lamp_d;
      alarm_on_o      <= alarm_d;
      alarm_event_o   <= ev_d;
      entry_number_o  <= '0;
      entry_value_o   <= '0;
      last_o          <= 1'b1;
    end else if (cmd_i.dump_out) begin
      temperature_c_o <= '0;
      lamp_on_o       <= lamp_q;
      alarm_on_o      <= alarm_q;
      alarm_event_o   <= EV_NONE;
      entry_number_o  <= NUM_W'(num_w);
      entry_value_o   <= rd_vld_q ? rd_data_q : ERASED_VAL;
      last_o          <= (cnt_q == CNT_LAST);
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.in_valid  = in_valid_i;
  assign sts_o.in_cmd    = cmd_in_i;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.dump_last = (cnt_q == CNT_LAST);

endmodule

[rtl/thermo_chk.sv]
// ----------------------------------------------------------------------------
// thermo_chk
// port-level checks of the thermostat, bound to the top level
// ----------------------------------------------------------------------------
module thermo_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [thermo_pkg::TEMP_W-1:0]  temperature_c_o,
  input logic                           alarm_on_o,
  input logic [thermo_pkg::EV_W-1:0]    alarm_event_o,
  input logic [thermo_pkg::NUM_W-1:0]   entry_number_o,
  input logic [thermo_pkg::ENTRY_W-1:0] entry_value_o,
  input logic                           last_o
);
  import thermo_pkg::*;

  `include "thermostat_with_alarm_and_history_assert.svh"

  // a stalled result word holds
  `THERMO_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(temperature_c_o) && $stable(entry_value_o) && $stable(last_o))

  // one word in work at a time
  `THERMO_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // dump words carry no temperature and no alarm event
  `THERMO_ASSERT_NOW(a_dump_fields, out_valid_o && entry_number_o != '0, temperature_c_o == '0 && alarm_event_o == EV_NONE)

  // a sample result is the only word of its command
  `THERMO_ASSERT_NOW(a_sample_last, out_valid_o && entry_number_o == '0, last_o && entry_value_o == '0)

  // reported event agrees with the alarm state
  `THERMO_ASSERT_NOW(a_event_state, out_valid_o && alarm_event_o != EV_NONE, (alarm_event_o == EV_RAISED && alarm_on_o) || (alarm_event_o == EV_CLEARED && !alarm_on_o))

endmodule

bind thermostat_with_alarm_and_history thermo_chk u_chk (.*);
